// ===== design/rdc_pkg.sv =====
// Package for the radix digit converter: widths, function and result codes,
// sequencer states, the control and status bundles and the digit helpers.
// Depends on nothing; every other file of the block imports it.
package rdc_pkg;

    localparam int VALUE_W    = 32;
    localparam int MAG_W      = VALUE_W - 1;
    localparam int WORK_W     = VALUE_W + 1;
    localparam int FUNC_W     = 3;
    localparam int KIND_W     = 2;
    localparam int CHAR_W     = 7;
    localparam int DEC_W      = 30;
    localparam int CNT_W      = 6;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int BIN_DEC_W  = BCD_DIGITS;
    localparam int OCT_DEC_W  = 3 * BCD_DIGITS;

    localparam logic [FUNC_W-1:0] FUNC_ENC_BIN = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENC_OCT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_ENC_HEX = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DEC_BIN = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DEC_OCT = 3'd4;

    localparam logic [KIND_W-1:0] KIND_DIGIT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VALUE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd3;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 7'h39;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_F    = 7'h46;

    localparam logic [CNT_W-1:0] DIGITS_BIN  = 6'd31;
    localparam logic [CNT_W-1:0] DIGITS_OCT  = 6'd11;
    localparam logic [CNT_W-1:0] DIGITS_HEX  = 6'd8;
    localparam logic [CNT_W-1:0] DABBLE_STEPS = CNT_W'(MAG_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SKIP,
        ST_EMIT,
        ST_DABBLE,
        ST_PACK,
        ST_SINGLE
    } state_t;

    typedef struct packed {
        logic              load;
        logic              shift;
        logic              dabble;
        logic [FUNC_W-1:0] mode;
    } ctrl_t;

    typedef struct packed {
        logic             in_empty;
        logic [3:0]       top_digit;
        logic             dec_ok;
        logic [DEC_W-1:0] dec_value;
    } status_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic              last;
    } emit_t;

    function automatic logic is_encode(input logic [FUNC_W-1:0] f);
        return (f == FUNC_ENC_BIN) || (f == FUNC_ENC_OCT) || (f == FUNC_ENC_HEX);
    endfunction

    function automatic logic is_decode(input logic [FUNC_W-1:0] f);
        return (f == FUNC_DEC_BIN) || (f == FUNC_DEC_OCT);
    endfunction

    function automatic logic [CNT_W-1:0] digit_count(input logic [FUNC_W-1:0] f);
        logic [CNT_W-1:0] n;
        unique case (f)
            FUNC_ENC_OCT: n = DIGITS_OCT;
            FUNC_ENC_HEX: n = DIGITS_HEX;
            default:      n = DIGITS_BIN;
        endcase
        return n;
    endfunction

    function automatic logic [CHAR_W-1:0] to_ascii(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
            c = ASCII_ZERO + {3'b000, d};
        else
            c = ASCII_A + {3'b000, d} - 7'd10;
        return c;
    endfunction

endpackage

// ===== design/radix_digit_converter.sv =====
// Radix digit converter, top level: sequencer, shared datapath and the
// output register. Depends on rdc_pkg, rdc_dp and rdc_ctl.
//
// Input channel (in_valid, in_stall, func, value): one item is a mode and
// a signed 32-bit value. Encode modes give one result per base-2, base-8 or
// base-16 digit as an ASCII character, most significant first; decode modes
// give one result holding the value of the decimal digits read in base 2 or
// base 8, or an error. A value of zero or below gives one result of kind
// "nothing to encode" or "error". Modes five to seven are taken and dropped.
// Output channel (out_valid, out_stall, kind, digit_char, decoded, last):
// last marks the final result of an item.
// Timing: in_stall stays high while an item is worked on. An encode takes
// the item, skips the leading zero digits, finds the first digit and then
// emits the digits one by one; a decode runs the bit-serial decimal digit
// extraction and then packs the result. A stalled result holds the
// sequencer, and the result register holds still meanwhile.
// Reset clears the sequencer and the output valid; the block comes up idle.
module radix_digit_converter
    import rdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [FUNC_W-1:0]  func,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [KIND_W-1:0]  kind,
    output logic [CHAR_W-1:0]  digit_char,
    output logic [DEC_W-1:0]   decoded,
    output logic               last
);

    ctrl_t   ctrl;
    status_t status;
    emit_t   emit;
    logic    out_free;

    logic              out_valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [CHAR_W-1:0] digit_char_reg;
    logic [DEC_W-1:0]  decoded_reg;
    logic              last_reg;

    assign out_free = !out_valid_reg || !out_stall;

    rdc_ctl u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .status   (status),
        .out_free (out_free),
        .in_stall (in_stall),
        .ctrl     (ctrl),
        .emit     (emit)
    );

    rdc_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .value  (value),
        .status (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit.valid)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            kind_reg       <= emit.kind;
            last_reg       <= emit.last;
            digit_char_reg <= (emit.kind == KIND_DIGIT) ? to_ascii(status.top_digit) : '0;
            decoded_reg    <= (emit.kind == KIND_VALUE) ? status.dec_value : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign digit_char = digit_char_reg;
    assign decoded    = decoded_reg;
    assign last       = last_reg;

`ifndef ASSERT_OFF
    // A new result is only written into a free output register.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> (!out_valid_reg || !out_stall))
        else $error("result written over a stalled result");

    // A digit result carries a proper digit character.
    a_digit_char: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_DIGIT) |->
            ((digit_char >= ASCII_ZERO && digit_char <= ASCII_NINE) ||
             (digit_char >= ASCII_A && digit_char <= ASCII_F)))
        else $error("digit result without a digit character");

    // Value, error and empty results each close their item.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != KIND_DIGIT) |-> last)
        else $error("non-digit result not marked last");
`endif

endmodule

// ===== design/rdc_dp.sv =====
// Datapath of the radix digit converter: the shared work shifter, the
// binary-to-decimal digit register and the digit packing for decodes.
// Depends on rdc_pkg.
module rdc_dp
    import rdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_t              ctrl,
    input  logic [VALUE_W-1:0] value,
    output status_t            status
);

    logic [WORK_W-1:0] work_reg, work_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [BCD_W-1:0]  bcd_adj;
    logic [MAG_W-1:0]  mag;
    logic [WORK_W-1:0] work_load;
    logic [WORK_W-1:0] work_shift;
    logic [BIN_DEC_W-1:0] bin_val;
    logic [OCT_DEC_W-1:0] oct_val;
    logic bin_ok;
    logic oct_ok;

    // Only a strictly positive value has anything to convert.
    assign mag = value[VALUE_W-1] ? '0 : value[MAG_W-1:0];

    // The most significant digit always sits at the top of the work word.
    always_comb
    begin
        unique case (ctrl.mode)
            FUNC_ENC_OCT: work_load = {2'b00, mag};
            FUNC_ENC_HEX: work_load = {1'b0, mag, 1'b0};
            default:      work_load = {mag, 2'b00};
        endcase
    end

    always_comb
    begin
        unique case (ctrl.mode)
            FUNC_ENC_OCT: work_shift = {work_reg[WORK_W-4:0], 3'b000};
            FUNC_ENC_HEX: work_shift = {work_reg[WORK_W-5:0], 4'b0000};
            default:      work_shift = {work_reg[WORK_W-2:0], 1'b0};
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        work_next = work_reg;
        bcd_next  = bcd_reg;
        if (ctrl.load)
        begin
            work_next = work_load;
            bcd_next  = '0;
        end
        else if (ctrl.dabble)
        begin
            work_next = {work_reg[WORK_W-2:0], 1'b0};
            bcd_next  = {bcd_adj[BCD_W-2:0], work_reg[WORK_W-1]};
        end
        else if (ctrl.shift)
        begin
            work_next = work_shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg <= '0;
            bcd_reg  <= '0;
        end
        else
        begin
            work_reg <= work_next;
            bcd_reg  <= bcd_next;
        end
    end

    // A decimal digit is a binary digit below two, an octal one below eight;
    // with a power-of-two base the decoded value is the digits laid side by side.
    always_comb
    begin
        bin_ok = 1'b1;
        oct_ok = 1'b1;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd2)
                bin_ok = 1'b0;
            if (bcd_reg[4*i +: 4] >= 4'd8)
                oct_ok = 1'b0;
            bin_val[i]       = bcd_reg[4*i];
            oct_val[3*i +: 3] = bcd_reg[4*i +: 3];
        end
    end

    always_comb
    begin
        status.in_empty = (mag == '0);
        unique case (ctrl.mode)
            FUNC_ENC_OCT: status.top_digit = {1'b0, work_reg[WORK_W-1 -: 3]};
            FUNC_ENC_HEX: status.top_digit = work_reg[WORK_W-1 -: 4];
            default:      status.top_digit = {3'b000, work_reg[WORK_W-1]};
        endcase
        if (ctrl.mode == FUNC_DEC_BIN)
        begin
            status.dec_ok    = bin_ok;
            status.dec_value = DEC_W'(bin_val);
        end
        else
        begin
            status.dec_ok    = oct_ok;
            status.dec_value = DEC_W'(oct_val);
        end
    end

endmodule

// ===== design/rdc_ctl.sv =====
// Sequencer of the radix digit converter: steps the shared shifter through
// leading-zero skipping, digit emission and decimal digit extraction.
// Depends on rdc_pkg.
module rdc_ctl
    import rdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [FUNC_W-1:0] func,
    input  status_t           status,
    input  logic              out_free,
    output logic              in_stall,
    output ctrl_t             ctrl,
    output emit_t             emit
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [FUNC_W-1:0] mode_reg, mode_next;
    logic [KIND_W-1:0] pend_kind_reg, pend_kind_next;
    logic              take;

    assign take = in_valid && (state_reg == ST_IDLE)
                  && (is_encode(func) || is_decode(func));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        mode_next      = mode_reg;
        pend_kind_next = pend_kind_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    mode_next = func;
                    if (status.in_empty)
                    begin
                        pend_kind_next = is_encode(func) ? KIND_EMPTY : KIND_ERROR;
                        state_next     = ST_SINGLE;
                    end
                    else if (is_encode(func))
                    begin
                        count_next = digit_count(func);
                        state_next = ST_SKIP;
                    end
                    else
                    begin
                        count_next = DABBLE_STEPS;
                        state_next = ST_DABBLE;
                    end
                end
            end
            ST_SKIP:
            begin
                if (status.top_digit == 4'd0)
                    count_next = count_reg - 1'b1;
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    count_next = count_reg - 1'b1;
                    if (count_reg == 6'd1)
                        state_next = ST_IDLE;
                end
            end
            ST_DABBLE:
            begin
                count_next = count_reg - 1'b1;
                if (count_reg == 6'd1)
                    state_next = ST_PACK;
            end
            ST_PACK:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_SINGLE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl.load   = 1'b0;
        ctrl.shift  = 1'b0;
        ctrl.dabble = 1'b0;
        ctrl.mode   = (state_reg == ST_IDLE) ? func : mode_reg;
        emit.valid  = 1'b0;
        emit.kind   = KIND_DIGIT;
        emit.last   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.load = take;
            end
            ST_SKIP:
            begin
                ctrl.shift = (status.top_digit == 4'd0);
            end
            ST_EMIT:
            begin
                ctrl.shift = out_free;
                emit.valid = out_free;
                emit.kind  = KIND_DIGIT;
                emit.last  = (count_reg == 6'd1);
            end
            ST_DABBLE:
            begin
                ctrl.dabble = 1'b1;
            end
            ST_PACK:
            begin
                emit.valid = out_free;
                emit.kind  = status.dec_ok ? KIND_VALUE : KIND_ERROR;
                emit.last  = 1'b1;
            end
            ST_SINGLE:
            begin
                emit.valid = out_free;
                emit.kind  = pend_kind_reg;
                emit.last  = 1'b1;
            end
            default:
            begin
                ctrl.load = 1'b0;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            mode_reg      <= FUNC_ENC_BIN;
            pend_kind_reg <= KIND_EMPTY;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            pend_kind_reg <= pend_kind_next;
        end
    end

endmodule

// ===== dv/rdc_checker.sv =====
// Scoreboard for the radix digit converter: watches both channels, predicts
// the results of each accepted item and compares them field by field.
// Depends on rdc_pkg for widths, function codes and result kinds.
module rdc_checker
    import rdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [FUNC_W-1:0]  func,
    input  logic [VALUE_W-1:0] value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [KIND_W-1:0]  kind,
    input  logic [CHAR_W-1:0]  digit_char,
    input  logic [DEC_W-1:0]   decoded,
    input  logic               last,
    output int                 failures,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] ch;
        logic [DEC_W-1:0]  dec;
        logic              last;
    } conv_result_t;

    conv_result_t expected_q[$];
    int           mismatches = 0;

    // Pushes the results that one accepted item should produce.
    function automatic void predict_conversion(input logic [FUNC_W-1:0] f,
                                               input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digits[$];
        logic [3:0]         digit_mask;
        logic [3:0]         d;
        logic [DEC_W-1:0]   acc;
        logic [DEC_W-1:0]   place;
        logic               positive;
        int                 shift;
        int                 base;
        conv_result_t       r;

        if (f > FUNC_DEC_OCT)
            return;
        positive = !v[VALUE_W-1] && (v != '0);

        if (f <= FUNC_ENC_HEX)
        begin
            if (!positive)
            begin
                r = '{KIND_EMPTY, '0, '0, 1'b1};
                expected_q.push_back(r);
                return;
            end
            shift = (f == FUNC_ENC_BIN) ? 1 : (f == FUNC_ENC_OCT) ? 3 : 4;
            digit_mask = 4'((1 << shift) - 1);
            mag = v;
            while (mag != '0)
            begin
                digits.push_front(mag[3:0] & digit_mask);
                mag = mag >> shift;
            end
            foreach (digits[i])
            begin
                d = digits[i];
                r.kind = KIND_DIGIT;
                r.ch   = (d < 4'd10) ? ASCII_ZERO + CHAR_W'(d)
                                     : ASCII_A + CHAR_W'(d) - CHAR_W'(10);
                r.dec  = '0;
                r.last = (i == digits.size() - 1);
                expected_q.push_back(r);
            end
            return;
        end

        // The decimal digits are read least significant first, as place
        // values of the chosen base.
        base = (f == FUNC_DEC_BIN) ? 2 : 8;
        if (!positive)
        begin
            r = '{KIND_ERROR, '0, '0, 1'b1};
            expected_q.push_back(r);
            return;
        end
        mag   = v;
        acc   = '0;
        place = DEC_W'(1);
        while (mag != '0)
        begin
            d = 4'(mag % 10);
            if (int'(d) >= base)
            begin
                r = '{KIND_ERROR, '0, '0, 1'b1};
                expected_q.push_back(r);
                return;
            end
            acc   = acc + DEC_W'(d) * place;
            place = place * DEC_W'(base);
            mag   = mag / 10;
        end
        r = '{KIND_VALUE, '0, acc, 1'b1};
        expected_q.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        conv_result_t want;
        if (!rst_n)
        begin
            expected_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_conversion(func, value);
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("kind: expected no result, got %0d", kind);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("kind", 32'(want.kind), 32'(kind));
                    check_field("digit_char", 32'(want.ch), 32'(digit_char));
                    check_field("decoded", 32'(want.dec), 32'(decoded));
                    check_field("last", 32'(want.last), 32'(last));
                end
            end
            outstanding <= expected_q.size();
        end
        failures <= mismatches;
    end

endmodule

// ===== dv/tb_radix_digit_converter.sv =====
// Testbench top for the radix digit converter: clock, reset, directed and
// random items, random stalls on the result side and the verdict.
// Depends on rdc_pkg, radix_digit_converter and rdc_checker.
module tb_radix_digit_converter;
    import rdc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [FUNC_W-1:0]  func = '0;
    logic [VALUE_W-1:0] value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  digit_char;
    logic [DEC_W-1:0]   decoded;
    logic               last;
    int                 failures;
    int                 outstanding;
    int                 idle_pct = 38;
    int                 quiet_cycles = 0;

    radix_digit_converter uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .digit_char (digit_char),
        .decoded    (decoded),
        .last       (last)
    );

    rdc_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .digit_char  (digit_char),
        .decoded     (decoded),
        .last        (last),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < idle_pct);

    // Ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    function automatic logic [VALUE_W-1:0] random_encode_value();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return '0;
            default: return $urandom >> $urandom_range(1, 31);
        endcase
    endfunction

    // Mostly well-formed numerals in the chosen base, some with one digit
    // pushed out of range, and a little plain noise.
    function automatic logic [VALUE_W-1:0] random_numeral(input logic [FUNC_W-1:0] f);
        int     base;
        int     len;
        int     pick;
        int     pos;
        int     old_digit;
        longint num;
        longint weight;

        pick = $urandom_range(0, 99);
        if (pick < 12)
            return $urandom;
        base = (f == FUNC_DEC_BIN) ? 2 : 8;
        len  = $urandom_range(1, 10);
        num  = (base == 8 && len < 10) ? $urandom_range(1, 7) : 1;
        for (int i = 1; i < len; i++)
            num = num * 10 + $urandom_range(0, base - 1);
        if (pick < 32)
        begin
            pos    = $urandom_range(0, len - 1);
            weight = 1;
            for (int i = 0; i < pos; i++)
                weight = weight * 10;
            old_digit = int'((num / weight) % 10);
            num = num + longint'(int'($urandom_range(base, 9)) - old_digit) * weight;
        end
        return num[VALUE_W-1:0];
    endfunction

    task automatic run_random(input int count);
        int                 done;
        int                 sel;
        logic [FUNC_W-1:0]  f;
        logic [VALUE_W-1:0] v;

        done = 0;
        while (done < count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
            begin
                f = FUNC_W'($urandom_range(5, 7));
                v = $urandom;
            end
            else if (sel < 50)
            begin
                f = FUNC_W'($urandom_range(FUNC_ENC_BIN, FUNC_ENC_HEX));
                v = random_encode_value();
            end
            else
            begin
                f = $urandom_range(0, 1) ? FUNC_DEC_BIN : FUNC_DEC_OCT;
                v = random_numeral(f);
            end
            send_item(f, v);
            if (f <= FUNC_DEC_OCT)
                done++;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes of each encode, digits A to F, nothing to encode.
        send_item(FUNC_ENC_BIN, 32'd1);
        send_item(FUNC_ENC_BIN, 32'h7FFF_FFFF);
        send_item(FUNC_ENC_OCT, 32'h7FFF_FFFF);
        send_item(FUNC_ENC_HEX, 32'h7FFF_FFFF);
        send_item(FUNC_ENC_HEX, 32'h00AB_CDEF);
        send_item(FUNC_ENC_OCT, 32'd8);
        send_item(FUNC_ENC_BIN, 32'd0);
        send_item(FUNC_ENC_HEX, 32'hFFFF_FFFF);
        send_item(FUNC_ENC_OCT, 32'h8000_0000);
        // Decodes: valid numerals, zero or negative, digits outside the base.
        send_item(FUNC_DEC_BIN, 32'd1011);
        send_item(FUNC_DEC_BIN, 32'd1111111111);
        send_item(FUNC_DEC_BIN, 32'd10);
        send_item(FUNC_DEC_OCT, 32'd1234567);
        send_item(FUNC_DEC_OCT, 32'd1777777777);
        send_item(FUNC_DEC_OCT, 32'd1000000000);
        send_item(FUNC_DEC_OCT, 32'd7);
        send_item(FUNC_DEC_OCT, 32'd2147483647);
        send_item(FUNC_DEC_BIN, 32'd1012);
        send_item(FUNC_DEC_OCT, 32'd98);
        send_item(FUNC_DEC_BIN, 32'd0);
        send_item(FUNC_DEC_BIN, -32'sd5);
        send_item(FUNC_DEC_OCT, 32'h8000_0000);
        // Unused function codes are taken and dropped.
        send_item(FUNC_W'(5), 32'd12);
        send_item(FUNC_W'(6), 32'hFFFF_FFFF);
        send_item(FUNC_W'(7), 32'h5555_5555);

        run_random(45);
        idle_pct = 0;
        run_random(35);
        in_valid <= 1'b0;
        wait_drained();
        idle_pct = 38;
        run_random(55);

        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
